>>> sv/jrd_pkg.sv
`default_nettype none

package jrd_pkg;

  localparam int POSE_COUNT = 9;
  localparam int CFG_W      = 64;

  // axis_setup layout
  localparam int AX_W        = 30;
  localparam int AX_EN       = 0;
  localparam int AX_BYTE_LSB = 1;
  localparam int AX_MASK_LSB = 4;
  localparam int AX_FLIP     = 12;
  localparam int AX_LO_LSB   = 13;
  localparam int AX_HI_LSB   = 21;
  localparam int AX_REV      = 29;
  localparam int LEN_LSB     = 60;

  localparam logic [7:0] BYTE_MASK = 8'hff;
  localparam logic [7:0] AXIS_FLIP = 8'h80;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam logic [3:0] DIR_UP    = 4'b0001;
  localparam logic [3:0] DIR_DOWN  = 4'b0010;
  localparam logic [3:0] DIR_LEFT  = 4'b0100;
  localparam logic [3:0] DIR_RIGHT = 4'b1000;

  // neutral, up, up-right, right, down-right, down, down-left, left, up-left
  localparam logic [3:0] POSE_DIRS [POSE_COUNT] = '{
    4'd0, 4'd1, 4'd9, 4'd8, 4'd10, 4'd2, 4'd6, 4'd4, 4'd5
  };

  typedef enum logic [2:0] {
    REG_A_MASK     = 3'd0,
    REG_A_PRESSED  = 3'd1,
    REG_B_MASK     = 3'd2,
    REG_B_PRESSED  = 3'd3,
    REG_FIXED_MASK = 3'd4,
    REG_FIXED_VAL  = 3'd5,
    REG_DIR_MASK   = 3'd6,
    REG_AXIS_SETUP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] axis_setup;
    logic [CFG_W-1:0] dir_mask;
    logic [CFG_W-1:0] fixed_value;
    logic [CFG_W-1:0] fixed_mask;
    logic [CFG_W-1:0] b_pressed;
    logic [CFG_W-1:0] b_mask;
    logic [CFG_W-1:0] a_pressed;
    logic [CFG_W-1:0] a_mask;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [3:0] entry_index;
    logic       fail;
    logic [1:0] buttons;
    logic       fixed_ok;
    logic [7:0] ax0;
    logic [7:0] ax1;
  } s1_ctl_t;

  typedef struct packed {
    logic                  fail;
    logic [1:0]            buttons;
    logic [POSE_COUNT-1:0] match;
  } s2_ctl_t;

endpackage

`default_nettype wire

>>> sv/jrd_cfg.sv
`default_nettype none

module jrd_cfg import jrd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_A_MASK:     cfg_nxt.a_mask      = cfg_data;
        REG_A_PRESSED:  cfg_nxt.a_pressed   = cfg_data;
        REG_B_MASK:     cfg_nxt.b_mask      = cfg_data;
        REG_B_PRESSED:  cfg_nxt.b_pressed   = cfg_data;
        REG_FIXED_MASK: cfg_nxt.fixed_mask  = cfg_data;
        REG_FIXED_VAL:  cfg_nxt.fixed_value = cfg_data;
        REG_DIR_MASK:   cfg_nxt.dir_mask    = cfg_data;
        REG_AXIS_SETUP: cfg_nxt.axis_setup  = cfg_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> sv/jrd_prep.sv
`default_nettype none

module jrd_prep import jrd_pkg::*; #(
  parameter int REPORT_BYTES = 8,
  localparam int RPT_W = 8 * REPORT_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [RPT_W-1:0] in_report_bytes,
  input  logic [3:0]       in_report_length,
  input  logic [3:0]       in_entry_index,
  input  logic [RPT_W-1:0] in_entry_value,
  input  logic             dn_ready,
  output logic             s1_valid,
  output s1_ctl_t          s1_ctl,
  output logic [RPT_W-1:0] s1_dir_bits,
  output logic [RPT_W-1:0] s1_len_mask,
  output logic [RPT_W-1:0] s1_entry_value
);

  logic             valid_r;
  s1_ctl_t          ctl_r, ctl_nxt;
  logic [RPT_W-1:0] dir_r, dir_nxt;
  logic [RPT_W-1:0] lm_r, lm_nxt;
  logic [RPT_W-1:0] val_r;

  logic [3:0]       len;
  logic             len_bad;
  logic [RPT_W-1:0] a_m, a_p, b_m, b_p;
  logic             a_pr, a_rel, b_pr, b_rel;
  logic [63:0]      rep64;
  logic [7:0]       axv [2];

  always_comb begin
    logic [AX_W-1:0] d;
    logic [7:0]      b;
    len     = cfg.axis_setup[LEN_LSB +: 4];
    len_bad = (in_report_length != len) || (len == 4'd0) ||
              ({1'b0, len} > 5'(REPORT_BYTES));
    for (int i = 0; i < REPORT_BYTES; i++) begin
      lm_nxt[8*i +: 8] = BYTE_MASK & {8{len > 4'(i)}};
    end
    a_m   = cfg.a_mask[RPT_W-1:0] & lm_nxt;
    a_p   = cfg.a_pressed[RPT_W-1:0] & lm_nxt;
    b_m   = cfg.b_mask[RPT_W-1:0] & lm_nxt;
    b_p   = cfg.b_pressed[RPT_W-1:0] & lm_nxt;
    a_pr  = (in_report_bytes & a_m) == a_p;
    a_rel = (in_report_bytes & a_m) == (a_p ^ a_m);
    b_pr  = (in_report_bytes & b_m) == b_p;
    b_rel = (in_report_bytes & b_m) == (b_p ^ b_m);

    // bytes past the report width read as zero
    rep64 = 64'(in_report_bytes);
    for (int a = 0; a < 2; a++) begin
      d = cfg.axis_setup[AX_W*a +: AX_W];
      b = rep64[{d[AX_BYTE_LSB +: 3], 3'b000} +: 8];
      if (d[AX_FLIP]) begin
        b = b ^ AXIS_FLIP;
      end
      axv[a] = b & d[AX_MASK_LSB +: 8];
    end

    ctl_nxt.req_type    = in_req_type;
    ctl_nxt.entry_index = in_entry_index;
    ctl_nxt.fail        = len_bad || (!a_pr && !a_rel) || (!b_pr && !b_rel);
    ctl_nxt.buttons     = {b_pr, a_pr};
    ctl_nxt.fixed_ok    = (in_report_bytes & cfg.fixed_mask[RPT_W-1:0] & lm_nxt) ==
                          (cfg.fixed_value[RPT_W-1:0] & lm_nxt);
    ctl_nxt.ax0         = axv[0];
    ctl_nxt.ax1         = axv[1];
    dir_nxt             = in_report_bytes & cfg.dir_mask[RPT_W-1:0] & lm_nxt;
  end

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctl_r <= ctl_nxt;
      dir_r <= dir_nxt;
      lm_r  <= lm_nxt;
      val_r <= in_entry_value;
    end
  end

  assign s1_valid       = valid_r;
  assign s1_ctl         = ctl_r;
  assign s1_dir_bits    = dir_r;
  assign s1_len_mask    = lm_r;
  assign s1_entry_value = val_r;

`ifndef SYNTH
  a_len_mismatch_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_DECODE &&
     in_report_length != cfg.axis_setup[LEN_LSB +: 4]) |=> ctl_r.fail)
    else $error("length mismatch not flagged as failure");
`endif

endmodule

`default_nettype wire

>>> sv/jrd_match.sv
`default_nettype none

module jrd_match import jrd_pkg::*; #(
  parameter int REPORT_BYTES = 8,
  localparam int RPT_W = 8 * REPORT_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             s1_valid,
  output logic             up_ready,
  input  s1_ctl_t          s1_ctl,
  input  logic [RPT_W-1:0] s1_dir_bits,
  input  logic [RPT_W-1:0] s1_len_mask,
  input  logic [RPT_W-1:0] s1_entry_value,
  input  logic             dn_ready,
  output logic             s2_valid,
  output s2_ctl_t          s2_ctl
);

  logic [RPT_W-1:0] tbl_r [POSE_COUNT];
  logic             valid_r;
  s2_ctl_t          ctl_r, ctl_nxt;
  logic             adv;
  logic [3:0]       axes, used;

  always_comb begin
    logic [AX_W-1:0] d;
    logic [3:0]      neg, pos;
    logic [7:0]      v;
    axes = '0;
    used = '0;
    for (int a = 0; a < 2; a++) begin
      d   = cfg.axis_setup[AX_W*a +: AX_W];
      neg = (a == 1) ? DIR_UP : DIR_LEFT;
      pos = (a == 1) ? DIR_DOWN : DIR_RIGHT;
      v   = (a == 1) ? s1_ctl.ax1 : s1_ctl.ax0;
      if (d[AX_EN]) begin
        used = used | neg | pos;
        if (v <= d[AX_LO_LSB +: 8]) begin
          axes = axes | (d[AX_REV] ? pos : neg);
        end else if (v >= d[AX_HI_LSB +: 8]) begin
          axes = axes | (d[AX_REV] ? neg : pos);
        end
      end
    end
    for (int p = 0; p < POSE_COUNT; p++) begin
      ctl_nxt.match[p] = ((POSE_DIRS[p] & used) == axes) && s1_ctl.fixed_ok &&
                         (s1_dir_bits == (tbl_r[p] & s1_len_mask));
    end
    ctl_nxt.fail    = s1_ctl.fail;
    ctl_nxt.buttons = s1_ctl.buttons;
  end

  assign up_ready = !valid_r || dn_ready;
  assign adv      = s1_valid && up_ready;

  // table writes and reads happen at the same stage, so request order holds
  always_ff @(posedge clk) begin
    if (adv && s1_ctl.req_type == REQ_WRITE) begin
      for (int p = 0; p < POSE_COUNT; p++) begin
        if (s1_ctl.entry_index == 4'(p)) begin
          tbl_r[p] <= s1_entry_value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= s1_valid && (s1_ctl.req_type == REQ_DECODE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2_ctl   = ctl_r;

`ifndef SYNTH
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_ctl.req_type == REQ_WRITE) |=> !valid_r)
    else $error("table write request produced a result");
`endif

endmodule

`default_nettype wire

>>> sv/joystick_report_decoder_top.sv
// Joystick report decoder.
// Input channel (in_*): one request per handshake. A decode request carries a
// report and its length and yields one result; a write request loads one
// direction table entry and yields no result.
// Result channel (out_*): decode_ok and the six joystick bits (zero on failure).
// Config channel (cfg_*): always ready; write registers only while idle.
// Pipeline: input stage (length, buttons, axis bytes), pose match stage with
// the direction table, pick stage feeding the output register. A decode
// result passes the three register stages (input, match, output) in turn, and
// one request can be taken every cycle unless out_ready stalls the pipeline.
// Reset clears all valid bits and the config registers. The direction table
// is not cleared; load every entry before decoding.
// When out_ready is held low the stages fill up behind the output register
// and in_ready drops; nothing is dropped or repeated.
`default_nettype none

module joystick_report_decoder_top import jrd_pkg::*; #(
  parameter int REPORT_BYTES = 8,
  localparam int RPT_W = 8 * REPORT_BYTES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_req_type,
  input  logic [RPT_W-1:0] in_report_bytes,
  input  logic [3:0]       in_report_length,
  input  logic [3:0]       in_entry_index,
  input  logic [RPT_W-1:0] in_entry_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_decode_ok,
  output logic [5:0]       out_joystick_bits
);

  cfg_t             cfg;
  logic             s1_valid, s1_ready;
  s1_ctl_t          s1_ctl;
  logic [RPT_W-1:0] s1_dir_bits, s1_len_mask, s1_entry_value;
  logic             s2_valid, s2_ready;
  s2_ctl_t          s2_ctl;

  logic             out_valid_r;
  logic             ok_r, ok_nxt;
  logic [5:0]       bits_r, bits_nxt;
  logic             hit;
  logic [3:0]       dirs;

  assign cfg_ready = 1'b1;

  jrd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jrd_prep #(.REPORT_BYTES(REPORT_BYTES)) u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_report_bytes  (in_report_bytes),
    .in_report_length (in_report_length),
    .in_entry_index   (in_entry_index),
    .in_entry_value   (in_entry_value),
    .dn_ready         (s1_ready),
    .s1_valid         (s1_valid),
    .s1_ctl           (s1_ctl),
    .s1_dir_bits      (s1_dir_bits),
    .s1_len_mask      (s1_len_mask),
    .s1_entry_value   (s1_entry_value)
  );

  jrd_match #(.REPORT_BYTES(REPORT_BYTES)) u_match (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .s1_valid       (s1_valid),
    .up_ready       (s1_ready),
    .s1_ctl         (s1_ctl),
    .s1_dir_bits    (s1_dir_bits),
    .s1_len_mask    (s1_len_mask),
    .s1_entry_value (s1_entry_value),
    .dn_ready       (s2_ready),
    .s2_valid       (s2_valid),
    .s2_ctl         (s2_ctl)
  );

  // first matching pose wins
  always_comb begin
    hit  = 1'b0;
    dirs = '0;
    for (int p = POSE_COUNT - 1; p >= 0; p--) begin
      if (s2_ctl.match[p]) begin
        hit  = 1'b1;
        dirs = POSE_DIRS[p];
      end
    end
    ok_nxt   = hit && !s2_ctl.fail;
    bits_nxt = ok_nxt ? {s2_ctl.buttons, dirs} : 6'd0;
  end

  assign s2_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      ok_r   <= ok_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_decode_ok     = ok_r;
  assign out_joystick_bits = bits_r;

`ifndef SYNTH
  a_fail_zero_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !ok_r) |-> (bits_r == 6'd0))
    else $error("failed decode carries joystick bits");

  a_no_opposite_dirs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ok_r) |-> !(bits_r[0] && bits_r[1]) && !(bits_r[2] && bits_r[3]))
    else $error("opposite directions both set");

  a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ready) |-> (s1_valid && s2_valid && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");
`endif

endmodule

`default_nettype wire
